[rtl/luhn_pkg.sv]
// Shared types, constants and functions for the card number Luhn check unit.
// Binary-to-BCD step helper and card type length table. No dependencies.
`default_nettype none

package luhn_pkg;

    localparam int MAX_DIGITS = 8;
    localparam int NUM_W      = 27;
    localparam int BCD_DIGITS = 9;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int PRE_BITS   = 3;
    localparam int STAGE_BITS = 8;
    localparam int NUM_STAGES = (NUM_W - PRE_BITS) / STAGE_BITS;
    localparam int REM_W      = NUM_W - PRE_BITS;
    localparam int COUNT_W    = 4;
    localparam int SUM_W      = 7;
    localparam int TYPE_W     = 2;

    localparam logic [TYPE_W-1:0] TYPE_A = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_B = 2'd1;
    localparam logic [TYPE_W-1:0] TYPE_C = 2'd2;

    localparam logic [COUNT_W-1:0] LEN_A    = 4'd8;
    localparam logic [COUNT_W-1:0] LEN_B    = 4'd7;
    localparam logic [COUNT_W-1:0] LEN_C    = 4'd6;
    localparam logic [COUNT_W-1:0] LEN_NONE = 4'hF;

    typedef struct packed {
        logic             valid;
        logic [BCD_W-1:0] bcd;
        logic [REM_W-1:0] rem;
    } dd_bus_t;

    function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd, input logic b);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (bcd[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], b};
    endfunction

    function automatic logic [COUNT_W-1:0] required_length(input logic [TYPE_W-1:0] t);
        logic [COUNT_W-1:0] len;
        case (t)
            TYPE_A:  len = LEN_A;
            TYPE_B:  len = LEN_B;
            TYPE_C:  len = LEN_C;
            default: len = LEN_NONE;
        endcase
        return len;
    endfunction

    function automatic logic [3:0] luhn_double(input logic [3:0] d);
        logic [4:0] twice;
        logic [4:0] red;
        twice = {d, 1'b0};
        red   = (twice >= 5'd10) ? twice - 5'd9 : twice;
        return red[3:0];
    endfunction

endpackage

`default_nettype wire

[rtl/luhn_dd_stage.sv]
// One pipeline stage of the binary-to-BCD conversion: STAGE_BITS shift-add-3 steps.
// Depends on luhn_pkg.
`default_nettype none

module luhn_dd_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire luhn_pkg::dd_bus_t in_bus,
    output luhn_pkg::dd_bus_t      out_bus
);
    import luhn_pkg::*;

    logic             valid_reg;
    logic [BCD_W-1:0] bcd_reg;
    logic [BCD_W-1:0] bcd_next;
    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] rem_next;

    always_comb
    begin
        bcd_next = in_bus.bcd;
        rem_next = in_bus.rem;
        for (int i = 0; i < STAGE_BITS; i++) begin
            bcd_next = dd_step(bcd_next, rem_next[REM_W-1]);
            rem_next = {rem_next[REM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_bus.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
        rem_reg <= rem_next;
    end

    assign out_bus.valid = valid_reg;
    assign out_bus.bcd   = bcd_reg;
    assign out_bus.rem   = rem_reg;

endmodule

`default_nettype wire

[rtl/luhn_eval.sv]
// Final stage: digit count, length check and Luhn sum from the BCD digits.
// Registers the result and its strobe. Depends on luhn_pkg.
`default_nettype none

module luhn_eval (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire luhn_pkg::dd_bus_t              in_bus,
    input  wire logic [luhn_pkg::TYPE_W-1:0]    card_type,
    output logic                                done,
    output logic [luhn_pkg::COUNT_W-1:0]        digit_count,
    output logic                                length_ok,
    output logic [luhn_pkg::SUM_W-1:0]          luhn_sum,
    output logic                                luhn_valid
);
    import luhn_pkg::*;

    logic               done_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               len_ok_reg;
    logic               len_ok_next;
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic               valid_reg;
    logic               valid_next;
    logic [3:0]         digit;

    always_comb
    begin
        count_next = '0;
        sum_next   = '0;
        digit      = '0;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            digit = in_bus.bcd[4*i +: 4];
            if (digit != 4'd0) begin
                count_next = COUNT_W'(i + 1);
            end
            if (i % 2 == 1) begin
                sum_next = sum_next + SUM_W'(luhn_double(digit));
            end else begin
                sum_next = sum_next + SUM_W'(digit);
            end
        end
        len_ok_next = (count_next == required_length(card_type));
        valid_next  = sum_next inside {7'd0, 7'd10, 7'd20, 7'd30, 7'd40,
                                       7'd50, 7'd60, 7'd70, 7'd80, 7'd90};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= in_bus.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg  <= count_next;
        len_ok_reg <= len_ok_next;
        sum_reg    <= sum_next;
        valid_reg  <= valid_next;
    end

    assign done        = done_reg;
    assign digit_count = count_reg;
    assign length_ok   = len_ok_reg;
    assign luhn_sum    = sum_reg;
    assign luhn_valid  = valid_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> digit_count <= COUNT_W'(MAX_DIGITS))
        else $error("digit count out of range");
    a_zero_number: assert property (@(posedge clk) disable iff (!rst_n)
        done && digit_count == '0 |-> luhn_sum == '0 && luhn_valid)
        else $error("zero number must give a zero valid sum");
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done && length_ok |-> digit_count != '0)
        else $error("length match with no digits");
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> luhn_sum <= SUM_W'(9 * MAX_DIGITS))
        else $error("Luhn sum beyond maximum");
`endif

endmodule

`default_nettype wire

[rtl/card_number_luhn_check_unit.sv]
// Top level of the card number Luhn check unit: input register, BCD pipeline, evaluation.
// Depends on luhn_pkg, luhn_dd_stage and luhn_eval.
//
// Usage:
//   Input: drive card_number and raise start; a transaction is taken at a
//   rising edge with start high and busy low. busy is always low, so one
//   number can be taken every cycle.
//   Config: cfg_we with cfg_wdata writes card_type (0 = 8 digits, 1 = 7,
//   2 = 6, 3 = no length matches). Write only while no transaction is in flight.
//   Output: done pulses for one cycle with digit_count, length_ok, luhn_sum
//   and luhn_valid. The receiver cannot stall the unit.
//   Pipeline: done comes through the input register, three 8-bit
//   binary-to-BCD stages and the result register.
//   Throughput: one transaction per cycle; the stage depth sets the latency.
//   Reset: rst_n asynchronously clears all valid flags and sets card_type
//   to 0; transactions in flight are dropped.
`default_nettype none

module card_number_luhn_check_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [luhn_pkg::NUM_W-1:0]     card_number,
    input  wire logic                           cfg_we,
    input  wire logic [luhn_pkg::TYPE_W-1:0]    cfg_wdata,
    output logic                                done,
    output logic [luhn_pkg::COUNT_W-1:0]        digit_count,
    output logic                                length_ok,
    output logic [luhn_pkg::SUM_W-1:0]          luhn_sum,
    output logic                                luhn_valid
);
    import luhn_pkg::*;

    logic              card_type_reg;
    logic [TYPE_W-1:0] type_reg;
    logic              in_valid_reg;
    logic [NUM_W-1:0]  num_reg;
    dd_bus_t           bus [NUM_STAGES+1];

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            type_reg      <= TYPE_A;
            in_valid_reg  <= 1'b0;
            card_type_reg <= 1'b0;
        end else begin
            in_valid_reg  <= start && !busy;
            card_type_reg <= cfg_we;
            if (cfg_we) begin
                type_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy) begin
            num_reg <= card_number;
        end
    end

    assign bus[0].valid = in_valid_reg;
    assign bus[0].bcd   = {{(BCD_W-PRE_BITS){1'b0}}, num_reg[NUM_W-1 -: PRE_BITS]};
    assign bus[0].rem   = num_reg[REM_W-1:0];

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        luhn_dd_stage u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .in_bus  (bus[g]),
            .out_bus (bus[g+1])
        );
    end

    luhn_eval u_eval (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_bus      (bus[NUM_STAGES]),
        .card_type   (type_reg),
        .done        (done),
        .digit_count (digit_count),
        .length_ok   (length_ok),
        .luhn_sum    (luhn_sum),
        .luhn_valid  (luhn_valid)
    );

`ifndef SYNTHESIS
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy asserted");
    a_type_write: assert property (@(posedge clk) disable iff (!rst_n)
        card_type_reg |-> type_reg == $past(cfg_wdata))
        else $error("card type write lost");
    a_type_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !card_type_reg && $past(rst_n) |-> $stable(type_reg))
        else $error("card type changed without a write");
`endif

endmodule

`default_nettype wire
